[hw/rtl/ekf_pkg.sv]
// Shared types and constants for the expiring key FIFO.
package ekf_pkg;

	localparam int KEY_W      = 32;
	localparam int TIME_W     = 48;
	localparam int DEADLINE_W = 49;
	localparam int LIFE_W     = 16;
	localparam int OCC_W      = 5;

	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd1000;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_FETCH  = 1'b1;

	typedef struct packed {
		logic                    command;
		logic signed [KEY_W-1:0] key_in;
		logic [TIME_W-1:0]       now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key_out;
		logic                    key_valid;
		logic                    dropped;
		logic [OCC_W-1:0]        occupancy;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_ACT
	} ekf_state_t;

	typedef struct packed {
		logic load_item;
		logic pop_stale;
		logic do_act;
	} ekf_cmd_t;

	typedef struct packed {
		logic stale;
		logic out_free;
	} ekf_stat_t;

endpackage

[hw/rtl/ekf_ctrl.sv]
// Controller state machine: sequences expiry walk and the command of each transaction.
module ekf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ekf_pkg::ekf_stat_t stat,
	output ekf_pkg::ekf_cmd_t  cmd
);

	ekf_pkg::ekf_state_t state_q;
	ekf_pkg::ekf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ekf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ekf_pkg::ST_IDLE: begin
				if (in_valid) state_d = ekf_pkg::ST_CHECK;
			end
			ekf_pkg::ST_CHECK: begin
				if (stat.stale) state_d = ekf_pkg::ST_READ;
				else state_d = ekf_pkg::ST_ACT;
			end
			ekf_pkg::ST_READ: begin
				state_d = ekf_pkg::ST_CHECK;
			end
			ekf_pkg::ST_ACT: begin
				if (stat.out_free) state_d = ekf_pkg::ST_IDLE;
			end
			default: begin
				state_d = ekf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.pop_stale = 1'b0;
		cmd.do_act    = 1'b0;
		case (state_q)
			ekf_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ekf_pkg::ST_CHECK: begin
				cmd.pop_stale = stat.stale;
			end
			ekf_pkg::ST_ACT: begin
				cmd.do_act = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/ekf_datapath.sv]
// Datapath: key and deadline ring, pointers, lifetime register and result register.
module ekf_datapath #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ekf_pkg::in_item_t  in_item,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  ekf_pkg::ekf_cmd_t  cmd,
	output ekf_pkg::ekf_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output ekf_pkg::out_item_t out_item
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic signed [ekf_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [ekf_pkg::DEADLINE_W-1:0]   dl_mem  [DEPTH];

	logic signed [ekf_pkg::KEY_W-1:0] rd_key_q;
	logic [ekf_pkg::DEADLINE_W-1:0]   rd_dl_q;

	logic                             cmd_q;
	logic signed [ekf_pkg::KEY_W-1:0] key_q;
	logic [ekf_pkg::TIME_W-1:0]       now_q;
	logic [ekf_pkg::LIFE_W-1:0]       lifetime_q;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	ekf_pkg::out_item_t out_q;

	logic             do_push;
	logic             do_pop;
	logic             empty;
	logic [CNT_W-1:0] count_d;
	logic [ekf_pkg::DEADLINE_W-1:0] deadline;

	assign empty    = (count_q == '0);
	assign deadline = {1'b0, now_q} + ekf_pkg::DEADLINE_W'(lifetime_q);
	assign do_push  = cmd.do_act && (cmd_q == ekf_pkg::CMD_SUBMIT) && (count_q != FULL_CNT);
	assign do_pop   = cmd.pop_stale
		|| (cmd.do_act && (cmd_q == ekf_pkg::CMD_FETCH) && !empty);

	always_comb begin
		count_d = count_q;
		if (do_push) count_d = count_q + CNT_W'(1);
		else if (do_pop) count_d = count_q - CNT_W'(1);
	end

	assign stat.stale    = !empty && (rd_dl_q < {1'b0, now_q});
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			key_mem[tail_q] <= key_q;
			dl_mem[tail_q]  <= deadline;
		end
		rd_key_q <= key_mem[head_q];
		rd_dl_q  <= dl_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q <= in_item.command;
			key_q <= in_item.key_in;
			now_q <= in_item.now_ms;
		end
		if (cmd.do_act) begin
			out_q.key_out   <= (do_pop) ? rd_key_q : '0;
			out_q.key_valid <= do_pop;
			out_q.dropped   <= (cmd_q == ekf_pkg::CMD_SUBMIT) && (count_q == FULL_CNT);
			out_q.occupancy <= ekf_pkg::OCC_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= ekf_pkg::LIFETIME_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) lifetime_q <= cfg_data;
			if (do_pop) head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
			if (do_push) tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
			count_q <= count_d;
			if (cmd.do_act) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hw/rtl/expiring_key_fifo.sv]
// Top level of the expiring key FIFO: controller plus datapath.
// The result is registered in ST_ACT, after ST_CHECK and one ST_READ/ST_CHECK pass per expired entry.
// A new transaction is taken only in ST_IDLE, once the last one is through; ST_ACT waits on the output, and
// the expiry walk drops one entry per pass over the registered-read ring memory.
// Reset: arst_n clears pointers, count, state and result valid; lifetime returns to 1000 ms.
// Ring contents are not cleared; an entry is read only after it was written.
module expiring_key_fifo #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ekf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ekf_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	ekf_pkg::ekf_cmd_t  cmd;
	ekf_pkg::ekf_stat_t stat;

	assign cfg_ready = 1'b1;

	ekf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ekf_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

[tb/tb_expiring_key_fifo.sv]
// Self-checking testbench for the expiring key FIFO, with its own predictor.
`timescale 1ns / 100ps

module tb_expiring_key_fifo;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 50;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	ekf_pkg::in_item_t          in_item = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	ekf_pkg::out_item_t         out_item;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [ekf_pkg::LIFE_W-1:0] cfg_data = '0;

	expiring_key_fifo #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [ekf_pkg::KEY_W-1:0] key_ring [DEPTH];
	logic [ekf_pkg::DEADLINE_W-1:0]   deadline_ring [DEPTH];
	int                               ring_head = 0;
	int                               ring_tail = 0;
	int                               held_count = 0;
	logic [ekf_pkg::LIFE_W-1:0]       life_ms = ekf_pkg::LIFETIME_RESET;

	ekf_pkg::in_item_t    pending_items [$];
	ekf_pkg::out_item_t   expected_results [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          accepted_count = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        steady = 1'b0;
	logic [ekf_pkg::TIME_W-1:0] now_clock = '0;

	function automatic ekf_pkg::out_item_t apply_key_event(ekf_pkg::in_item_t it);
		ekf_pkg::out_item_t res;
		res = '0;
		while (held_count != 0 && deadline_ring[ring_head] < {1'b0, it.now_ms}) begin
			ring_head = (ring_head + 1) % DEPTH;
			held_count--;
		end
		if (it.command == ekf_pkg::CMD_SUBMIT) begin
			if (held_count >= DEPTH)
				res.dropped = 1'b1;
			else begin
				key_ring[ring_tail] = it.key_in;
				deadline_ring[ring_tail] = {1'b0, it.now_ms} + {33'd0, life_ms};
				ring_tail = (ring_tail + 1) % DEPTH;
				held_count++;
			end
		end else if (held_count != 0) begin
			res.key_out = key_ring[ring_head];
			res.key_valid = 1'b1;
			ring_head = (ring_head + 1) % DEPTH;
			held_count--;
		end
		res.occupancy = ekf_pkg::OCC_W'(held_count);
		return res;
	endfunction

	function automatic logic take_break();
		return !steady && $urandom_range(0, 99) < 11;
	endfunction

	task automatic report(input string what);
		if (mismatches < 100)
			$display("cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic queue_item(input logic cmd, input logic [ekf_pkg::KEY_W-1:0] key,
			input logic [ekf_pkg::TIME_W-1:0] t);
		ekf_pkg::in_item_t it;
		it.command = cmd;
		it.key_in = key;
		it.now_ms = t;
		pending_items.push_back(it);
	endtask

	task automatic drain_and_settle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_lifetime(input logic [ekf_pkg::LIFE_W-1:0] value);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		life_ms = value;
		cfg_valid <= 1'b0;
	endtask

	// random key events; submit bias swings every 32 transactions to fill and drain
	task automatic random_events(input int n, input int still_pct, input int step_max);
		int r;
		logic [ekf_pkg::TIME_W:0] next_time;
		logic cmd;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			next_time = {1'b0, now_clock};
			if (r >= still_pct && r < 97)
				next_time += (ekf_pkg::TIME_W + 1)'($urandom_range(1, step_max));
			else if (r >= 97)
				next_time += (ekf_pkg::TIME_W + 1)'($urandom_range(int'(life_ms),
					2 * int'(life_ms) + 2));
			now_clock = next_time[ekf_pkg::TIME_W] ? '1 : next_time[ekf_pkg::TIME_W-1:0];
			cmd = ($urandom_range(0, 99) < (((k / 32) % 2) ? 30 : 75))
				? ekf_pkg::CMD_SUBMIT : ekf_pkg::CMD_FETCH;
			queue_item(cmd, $urandom, now_clock);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_key_event(in_item));
				accepted_count <= accepted_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					in_item <= pending_items.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		ekf_pkg::out_item_t want;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report($sformatf("unexpected result key %h", out_item.key_out));
				else begin
					want = expected_results.pop_front();
					if (out_item.key_out !== want.key_out
							|| out_item.key_valid !== want.key_valid
							|| out_item.dropped !== want.dropped
							|| out_item.occupancy !== want.occupancy)
						report($sformatf(
							"got key %h valid %b dropped %b occ %0d, want %h %b %b %0d",
							out_item.key_out, out_item.key_valid, out_item.dropped,
							out_item.occupancy, want.key_out, want.key_valid,
							want.dropped, want.occupancy));
				end
			end
			out_ready <= hold_left == 0 && !take_break();
		end
	end

	initial begin
		logic [ekf_pkg::LIFE_W-1:0] life;

		// directed: empty fetch, key extremes, deadline boundary, fill, drop,
		// time going backward, full expiry
		queue_item(ekf_pkg::CMD_FETCH, 32'h0000_1234, 48'd0);
		queue_item(ekf_pkg::CMD_SUBMIT, 32'h7FFF_FFFF, 48'd0);
		queue_item(ekf_pkg::CMD_SUBMIT, 32'h8000_0000, 48'd0);
		queue_item(ekf_pkg::CMD_SUBMIT, 32'h0000_0000, 48'd5);
		queue_item(ekf_pkg::CMD_SUBMIT, 32'hFFFF_FFFF, 48'd10);
		queue_item(ekf_pkg::CMD_FETCH, 32'hFFFF_FFFF, 48'd1000);
		queue_item(ekf_pkg::CMD_FETCH, 32'h0, 48'd1001);
		for (int i = 0; i < DEPTH + 1; i++)
			queue_item(ekf_pkg::CMD_SUBMIT, 32'hA5A5_0000 + i, 48'd2000);
		queue_item(ekf_pkg::CMD_FETCH, 32'h0, 48'd1500);
		queue_item(ekf_pkg::CMD_FETCH, 32'h0, 48'd5000);
		now_clock = 48'd5000;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_lifetime(16'd0);
		random_events(200, 90, 1);

		write_lifetime(16'd1);
		steady = 1'b1;
		random_events(250, 85, 2);
		drain_and_settle();
		steady = 1'b0;

		write_lifetime(16'hFFFF);
		random_events(250, 40, 16'hFFFF / 12 + 1);

		for (int p = 0; p < 4; p++) begin
			life = ekf_pkg::LIFE_W'($urandom_range(2, 3000));
			write_lifetime(life);
			random_events(200, 40, life / 12 + 1);
		end

		life = ekf_pkg::LIFE_W'($urandom_range(1, 16'hFFFF));
		write_lifetime(life);
		now_clock = ekf_pkg::TIME_W'({$urandom, $urandom});
		random_events(150, 40, life / 12 + 1);

		// top of the time range, deadlines past 48 bits
		write_lifetime(16'hFFFF);
		now_clock = 48'hFFFF_FFFF_0000;
		random_events(200, 40, 16'hFFFF / 12 + 1);

		drain_and_settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
